// File: design/apr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants of the addressed packet receiver.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam logic [7:0] START_BYTE = 8'h40;
    localparam logic [7:0] END_BYTE   = 8'h0D;

    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_BOARD_ADDR = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BCAST_ADDR = 1'b1;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_ADDRESS = 3'd1,
        PH_COMMAND = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_DATA    = 3'd4,
        PH_CHECK   = 3'd5,
        PH_END     = 3'd6
    } phase_t;

    typedef struct packed {
        logic incoming;
        logic bcast;
        logic board;
        logic line_err;
        logic end_err;
        logic check_err;
        logic complete;
    } flags_t;

    // packed so that the first field lands in the highest bits
    typedef struct packed {
        logic [7:0] data_value;
        logic [7:0] data_index;
        logic       data_valid;
        logic [7:0] data_length;
        logic [7:0] command_byte;
        flags_t     flags;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage
`default_nettype wire

// File: design/addressed_packet_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// addressed_packet_receiver
// Deframer for addressed serial packets with xor check and data byte output.
// ----------------------------------------------------------------------------
// Every received byte beat yields exactly one registered result beat, and a
// byte can be taken on every clock while the skid stage is empty, so the rate
// is then one byte per cycle; the parser state registers reach the output
// register through byte compares and muxes. A two-entry output buffer (output
// register plus skid stage) lets input keep flowing for one beat while the
// output side stalls. Packet format: 0x40, address, command, length, data
// bytes, xor of command and data, 0x0D. The address registers may be written
// between packets; a write mid-packet applies from the next address byte.
// ----------------------------------------------------------------------------
module addressed_packet_receiver (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // rx_byte
    input  wire logic [0:0]                       s_tuser,  // line_error
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // packet_complete, check_error, end_error, low_level_error,
    // for_this_board, is_broadcast, packet_incoming, command_byte[7:0],
    // data_length[7:0], data_valid, data_index[7:0], data_value[7:0]
    output logic [apr_pkg::RESULT_W-1:0]          m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [apr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [apr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [7:0]       board_addr_reg;
    logic [7:0]       bcast_addr_reg;
    logic             accept;
    apr_pkg::result_t parse_result;
    apr_pkg::result_t out_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_addr_reg <= 8'd1;
            bcast_addr_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                apr_pkg::REG_BOARD_ADDR: board_addr_reg <= cfg_wdata;
                apr_pkg::REG_BCAST_ADDR: bcast_addr_reg <= cfg_wdata;
                default:                 board_addr_reg <= board_addr_reg;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    apr_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .rx_byte           (s_tdata),
        .line_error        (s_tuser[0]),
        .own_address       (board_addr_reg),
        .broadcast_address (bcast_addr_reg),
        .result            (parse_result)
    );

    apr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parse_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = out_result;

endmodule
`default_nettype wire

// File: design/apr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apr_parser
// Packet phase machine, match flags, xor check and the result of each byte.
// ----------------------------------------------------------------------------
module apr_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             line_error,
    input  wire logic [7:0]       own_address,
    input  wire logic [7:0]       broadcast_address,
    output apr_pkg::result_t      result
);

    apr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      count_reg, count_next;
    logic [7:0]      acc_reg, acc_next;
    logic [7:0]      command_reg, command_next;
    logic [7:0]      length_reg, length_next;
    apr_pkg::flags_t flags_reg, flags_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= apr_pkg::PH_START;
            count_reg   <= '0;
            acc_reg     <= '0;
            command_reg <= '0;
            length_reg  <= '0;
            flags_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            flags_reg   <= flags_next;
        end
    end

    always_comb
    begin
        logic [7:0] count_inc;
        count_inc    = count_reg + 8'd1;
        phase_next   = phase_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        command_next = command_reg;
        length_next  = length_reg;
        flags_next   = flags_reg;
        result.data_valid = 1'b0;
        result.data_index = '0;
        result.data_value = '0;

        if (line_error)
        begin
            flags_next.line_err = 1'b1;
        end
        else
        begin
            case (phase_reg)
                apr_pkg::PH_START:
                begin
                    if (rx_byte == apr_pkg::START_BYTE)
                    begin
                        flags_next.incoming = 1'b1;
                        flags_next.complete = 1'b0;
                        count_next          = '0;
                        phase_next          = apr_pkg::PH_ADDRESS;
                    end
                    else
                    begin
                        flags_next.incoming = 1'b0;
                    end
                end
                apr_pkg::PH_ADDRESS:
                begin
                    // board match wins when both addresses are equal
                    flags_next.board = (rx_byte == own_address);
                    flags_next.bcast = (rx_byte != own_address) &&
                                       (rx_byte == broadcast_address);
                    phase_next       = apr_pkg::PH_COMMAND;
                end
                apr_pkg::PH_COMMAND:
                begin
                    command_next = rx_byte;
                    if (flags_reg.board)
                    begin
                        acc_next = rx_byte;
                    end
                    phase_next = apr_pkg::PH_LENGTH;
                end
                apr_pkg::PH_LENGTH:
                begin
                    length_next = rx_byte;
                    phase_next  = (rx_byte == 8'd0) ? apr_pkg::PH_CHECK
                                                    : apr_pkg::PH_DATA;
                end
                apr_pkg::PH_DATA:
                begin
                    if (flags_reg.board)
                    begin
                        result.data_valid = 1'b1;
                        result.data_index = count_reg;
                        result.data_value = rx_byte;
                        acc_next          = acc_reg ^ rx_byte;
                    end
                    count_next = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        phase_next = apr_pkg::PH_CHECK;
                    end
                end
                apr_pkg::PH_CHECK:
                begin
                    if (flags_reg.board)
                    begin
                        flags_next.check_err = (acc_reg != rx_byte);
                    end
                    phase_next = apr_pkg::PH_END;
                end
                apr_pkg::PH_END:
                begin
                    flags_next.end_err  = (rx_byte != apr_pkg::END_BYTE);
                    flags_next.complete = 1'b1;
                    phase_next          = apr_pkg::PH_START;
                end
                default:
                begin
                    phase_next = apr_pkg::PH_START;
                end
            endcase
        end

        result.flags        = flags_next;
        result.command_byte = command_next;
        result.data_length  = length_next;
    end

`ifndef ASSERT_OFF
    a_match_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(flags_reg.board && flags_reg.bcast))
        else $error("board and broadcast match both set");

    a_line_error_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && line_error |=> $stable(phase_reg) && $stable(count_reg))
        else $error("line error changed parser state");

    a_data_only_for_board: assert property (@(posedge clk) disable iff (!rst_n)
        result.data_valid |-> phase_reg == apr_pkg::PH_DATA && flags_reg.board
                              && !line_error)
        else $error("data byte emitted outside a board packet");
`endif

endmodule
`default_nettype wire

// File: design/apr_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apr_out_buf
// Output register with a skid stage, decouples input ready from output ready.
// ----------------------------------------------------------------------------
module apr_out_buf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire apr_pkg::result_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output apr_pkg::result_t     out_data
);

    apr_pkg::result_t out_reg, out_next;
    apr_pkg::result_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             push;
    logic             pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            // skid full means no push this cycle
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = in_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while the output is empty");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the addressed packet receiver: streams received
// bytes (framed packets, noise, broken frames, line errors) through the slave
// port under random sender gaps and receiver stalls, and compares every result
// beat against a cycle-free model of the deframer kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

    import apr_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;     // rx_byte
    logic [0:0]            s_tuser = 1'b0;      // line_error
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [RESULT_W-1:0]   m_tdata;             // see result_t, flags lowest
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    addressed_packet_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // deframer model state
    logic [7:0] board_addr = 8'h01;
    logic [7:0] bcast_addr = 8'h00;
    phase_t     parse_phase = PH_START;
    logic [7:0] payload_cnt = 8'h00;
    logic [7:0] xor_acc = 8'h00;
    logic [7:0] cur_cmd = 8'h00;
    logic [7:0] cur_len = 8'h00;
    flags_t     status = '0;

    result_t pending_results[$];
    int      mismatches = 0;
    int      bytes_sent = 0;

    // traffic shaping
    int         send_mode = 0;
    int         ready_mode = 0;
    int         burst_left = 0;
    logic [15:0] stall_word = 16'hffff;
    int         stall_pos = 0;

    function automatic result_t parse_byte(input logic [7:0] b, input logic lerr);
        result_t r;
        r = '0;
        if (lerr)
        begin
            status.line_err = 1'b1;
        end
        else
        begin
            case (parse_phase)
                PH_START:
                begin
                    if (b == START_BYTE)
                    begin
                        status.incoming = 1'b1;
                        status.complete = 1'b0;
                        payload_cnt = 8'h00;
                        parse_phase = PH_ADDRESS;
                    end
                    else
                    begin
                        status.incoming = 1'b0;
                    end
                end
                PH_ADDRESS:
                begin
                    // board match wins over broadcast
                    status.board = (b == board_addr);
                    status.bcast = (b != board_addr) && (b == bcast_addr);
                    parse_phase = PH_COMMAND;
                end
                PH_COMMAND:
                begin
                    cur_cmd = b;
                    if (status.board)
                        xor_acc = b;
                    parse_phase = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    cur_len = b;
                    parse_phase = (b == 8'h00) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    if (status.board)
                    begin
                        r.data_valid = 1'b1;
                        r.data_index = payload_cnt;
                        r.data_value = b;
                        xor_acc = xor_acc ^ b;
                    end
                    payload_cnt = payload_cnt + 8'd1;
                    if (payload_cnt >= cur_len)
                        parse_phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    if (status.board)
                        status.check_err = (xor_acc != b);
                    parse_phase = PH_END;
                end
                PH_END:
                begin
                    status.end_err = (b != END_BYTE);
                    status.complete = 1'b1;
                    parse_phase = PH_START;
                end
                default:
                    parse_phase = PH_START;
            endcase
        end
        r.flags = status;
        r.command_byte = cur_cmd;
        r.data_length = cur_len;
        return r;
    endfunction

    // input beats feed the model
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_results.push_back(parse_byte(s_tdata, s_tuser[0]));
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name,
                         want, got);
        end
    endtask

    // result beats are checked against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat %0h", $realtime, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("packet_complete", 8'(want.flags.complete),
                            8'(got.flags.complete));
                check_field("check_error", 8'(want.flags.check_err),
                            8'(got.flags.check_err));
                check_field("end_error", 8'(want.flags.end_err), 8'(got.flags.end_err));
                check_field("low_level_error", 8'(want.flags.line_err),
                            8'(got.flags.line_err));
                check_field("for_this_board", 8'(want.flags.board), 8'(got.flags.board));
                check_field("is_broadcast", 8'(want.flags.bcast), 8'(got.flags.bcast));
                check_field("packet_incoming", 8'(want.flags.incoming),
                            8'(got.flags.incoming));
                check_field("command_byte", want.command_byte, got.command_byte);
                check_field("data_length", want.data_length, got.data_length);
                check_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
                check_field("data_index", want.data_index, got.data_index);
                check_field("data_value", want.data_value, got.data_value);
            end
        end
    end

    // receiver stall pattern, reloaded when the bit position wraps
    always @(posedge clk)
    begin
        if (stall_pos == 0)
            stall_word = 16'($urandom);
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= stall_word[stall_pos];
            default: m_tready <= stall_word[stall_pos] & stall_word[(stall_pos + 5) % 16];
        endcase
        stall_pos = (stall_pos + 1) % 16;
    end

    task automatic send_byte(input logic [7:0] b, input logic lerr);
        int gap;
        if (burst_left == 0)
        begin
            case (send_mode)
                0:
                begin
                    burst_left = 64;
                    gap = 0;
                end
                1:
                begin
                    burst_left = $urandom_range(1, 16);
                    gap = $urandom_range(0, 3);
                end
                default:
                begin
                    burst_left = $urandom_range(1, 4);
                    gap = $urandom_range(1, 12);
                end
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= lerr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // called in the time step of the last input beat
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        @(posedge clk);
    endtask

    // leaves the write enable high, the caller drops it after the last write
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_BOARD_ADDR)
            board_addr = val;
        else
            bcast_addr = val;
    endtask

    task automatic set_addresses(input logic [7:0] board, input logic [7:0] bcast);
        wait_drained();
        write_reg(REG_BOARD_ADDR, board);
        write_reg(REG_BCAST_ADDR, bcast);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_packet(input logic [7:0] addr, input int len, input bit bad_check,
                               input bit bad_end, input bit truncate, input int lerr_pct);
        logic [7:0] frame[$];
        logic [7:0] cmd;
        logic [7:0] chk;
        logic [7:0] d;
        int         keep;
        cmd = 8'($urandom);
        chk = cmd;
        frame = {START_BYTE, addr, cmd, 8'(len)};
        for (int i = 0; i < len; i++)
        begin
            d = 8'($urandom);
            chk = chk ^ d;
            frame.push_back(d);
        end
        frame.push_back(bad_check ? chk ^ 8'($urandom_range(1, 255)) : chk);
        if (bad_end)
        begin
            d = 8'($urandom);
            if (d == END_BYTE)
                d = ~d;
            frame.push_back(d);
        end
        else
        begin
            frame.push_back(END_BYTE);
        end
        keep = truncate ? $urandom_range(1, frame.size() - 1) : frame.size();
        for (int i = 0; i < keep; i++)
        begin
            if ($urandom_range(0, 99) < lerr_pct)
                send_byte(8'($urandom), 1'b1);
            send_byte(frame[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] pick_address();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return board_addr;
        else if (p < 65)
            return bcast_addr;
        return 8'($urandom);
    endfunction

    function automatic int pick_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(0, 4);
        return $urandom_range(5, 16);
    endfunction

    // framing, check, end byte and line error cases at the reset addresses
    task automatic test_directed();
        logic [7:0] seq[$];
        seq = {8'hff, 8'h00,
               8'h40, 8'h01, 8'ha5, 8'h02, 8'h00, 8'hff, 8'h5a, 8'h0d,
               8'h40, 8'h00, 8'hff, 8'h00, 8'h33, 8'h0d,
               8'h40, 8'h01, 8'h12, 8'h01, 8'h55, 8'h34, 8'h00, 8'hee};
        // line error lands on a data byte of the last frame
        for (int i = 0; i < seq.size(); i++)
            send_byte(seq[i], i == 20);
        // unmatched address, then a fresh start clears complete
        send_packet(8'h7e, 3, 1'b0, 1'b0, 1'b0, 0);
        wait_drained();
    endtask

    // corner register settings including equal addresses
    task automatic test_address_extremes();
        logic [7:0] boards[4];
        logic [7:0] bcasts[4];
        boards = '{8'hff, 8'h00, 8'h5a, 8'h40};
        bcasts = '{8'h00, 8'hff, 8'h5a, 8'h0d};
        for (int s = 0; s < 4; s++)
        begin
            set_addresses(boards[s], bcasts[s]);
            send_mode = s % 3;
            ready_mode = (s + 1) % 3;
            send_packet(board_addr, 2, 1'b0, 1'b0, 1'b0, 0);
            send_packet(bcast_addr, 1, 1'b0, 1'b0, 1'b0, 0);
            send_packet(~board_addr, 0, 1'b1, 1'b0, 1'b0, 0);
            send_packet(board_addr, 0, 1'b1, 1'b1, 1'b0, 0);
        end
        wait_drained();
    endtask

    // random frames, noise and broken frames across settings and pacing
    task automatic test_random_traffic();
        int target;
        int p;
        for (int seg = 0; seg < 6; seg++)
        begin
            if (seg % 2 == 0)
                set_addresses(8'($urandom), 8'($urandom));
            else
                set_addresses(board_addr, board_addr ^ 8'($urandom_range(0, 1)));
            send_mode = $urandom_range(0, 2);
            ready_mode = $urandom_range(0, 2);
            if (seg == 5)
            begin
                send_mode = 0;
                ready_mode = 0;
            end
            target = bytes_sent + 75;
            if (seg == 3)
                send_packet(board_addr, 255, 1'b0, 1'b0, 1'b0, 0);
            while (bytes_sent < target)
            begin
                p = $urandom_range(0, 99);
                if (p < 10)
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom), $urandom_range(0, 19) == 0);
                else
                    send_packet(pick_address(), pick_length(), p >= 10 && p < 20,
                                p >= 20 && p < 25, p >= 25 && p < 30, 3);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_address_extremes();
        test_random_traffic();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
